[hdl/depth_pixel_backprojection_assert.svh]
// assertion macros for the depth pixel back-projection block
// used by the port checker; needs nothing else
`ifndef DEPTH_PIXEL_BACKPROJECTION_ASSERT_SVH
`define DEPTH_PIXEL_BACKPROJECTION_ASSERT_SVH

// same-cycle implication under reset
`define DPBP_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define DPBP_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/dpbp_pkg.sv]
// shared types and constants of the depth pixel back-projection block
// no dependencies
`default_nettype none

package dpbp_pkg;

    localparam int NUM_W     = 48;
    localparam int DEN_W     = 32;
    localparam int DIV_STEPS = NUM_W;
    localparam int LANES     = 3;
    localparam int LANE_X    = 0;
    localparam int LANE_Y    = 1;
    localparam int LANE_Z    = 2;

    localparam logic [NUM_W-1:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;
    localparam logic [NUM_W-1:0] NEG_LIMIT = 48'h8000_0000_0000;

    typedef enum logic [2:0] {
        REG_DEPTH_SCALE = 3'd0,
        REG_CENTER_X    = 3'd1,
        REG_CENTER_Y    = 3'd2,
        REG_FOCAL_X     = 3'd3,
        REG_FOCAL_Y     = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] depth_scale;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] focal_x;
        logic [15:0] focal_y;
    } cfg_t;

    // per-item data that rides along with the divider
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       neg_x;
        logic       neg_y;
        logic       zero_x;
        logic       zero_y;
    } side_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_op_t;

endpackage

`default_nettype wire

[hdl/dpbp_prep.sv]
// front stages: pixel checks, offsets from the principal point, products
// depends on dpbp_pkg
`default_nettype none

module dpbp_prep #(
    parameter int MAX_COLS = 4096,
    parameter int MAX_ROWS = 4096
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire dpbp_pkg::cfg_t       cfg,
    input  wire logic                 in_valid,
    input  wire logic [11:0]          pixel_column,
    input  wire logic [11:0]          pixel_row,
    input  wire logic [15:0]          depth_raw,
    input  wire logic [7:0]           blue_in,
    input  wire logic [7:0]           green_in,
    input  wire logic [7:0]           red_in,
    output logic                      out_valid,
    output dpbp_pkg::side_t           out_side,
    output dpbp_pkg::div_op_t         out_ops [dpbp_pkg::LANES]
);
    import dpbp_pkg::*;

    localparam logic [14:0] COL_LIMIT = 15'(MAX_COLS);
    localparam logic [14:0] ROW_LIMIT = 15'(MAX_ROWS);

    logic        keep;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        neg_x;
    logic        neg_y;
    logic [15:0] off_x;
    logic [15:0] off_y;

    logic        a_valid_reg;
    side_t       a_side_reg;
    logic [15:0] a_off_x_reg;
    logic [15:0] a_off_y_reg;
    logic [15:0] a_depth_reg;

    logic        b_valid_reg;
    side_t       b_side_reg;
    logic [31:0] b_prod_x_reg;
    logic [31:0] b_prod_y_reg;
    logic [31:0] b_den_x_reg;
    logic [31:0] b_den_y_reg;
    logic [15:0] b_depth_reg;
    logic [15:0] b_scale_reg;

    // zero depth and pixels outside the image leave a bubble
    assign keep = (depth_raw != 16'd0)
               && ({3'b000, pixel_column} < COL_LIMIT)
               && ({3'b000, pixel_row} < ROW_LIMIT);

    assign pos_x = {pixel_column, 4'b0000};
    assign pos_y = {pixel_row, 4'b0000};
    assign neg_x = pos_x < cfg.center_x;
    assign neg_y = pos_y < cfg.center_y;
    assign off_x = neg_x ? (cfg.center_x - pos_x) : (pos_x - cfg.center_x);
    assign off_y = neg_y ? (cfg.center_y - pos_y) : (pos_y - cfg.center_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid && keep;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg.blue   <= blue_in;
            a_side_reg.green  <= green_in;
            a_side_reg.red    <= red_in;
            a_side_reg.neg_x  <= neg_x;
            a_side_reg.neg_y  <= neg_y;
            a_side_reg.zero_x <= (off_x == 16'd0);
            a_side_reg.zero_y <= (off_y == 16'd0);
            a_off_x_reg       <= off_x;
            a_off_y_reg       <= off_y;
            a_depth_reg       <= depth_raw;

            b_side_reg   <= a_side_reg;
            b_prod_x_reg <= a_off_x_reg * a_depth_reg;
            b_prod_y_reg <= a_off_y_reg * a_depth_reg;
            b_den_x_reg  <= cfg.depth_scale * cfg.focal_x;
            b_den_y_reg  <= cfg.depth_scale * cfg.focal_y;
            b_depth_reg  <= a_depth_reg;
            b_scale_reg  <= cfg.depth_scale;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_side  = b_side_reg;

    assign out_ops[LANE_X] = '{num: {b_prod_x_reg, 16'h0000}, den: b_den_x_reg};
    assign out_ops[LANE_Y] = '{num: {b_prod_y_reg, 16'h0000}, den: b_den_y_reg};
    assign out_ops[LANE_Z] = '{num: {16'h0000, b_depth_reg, 16'h0000},
                               den: {16'h0000, b_scale_reg}};

endmodule

`default_nettype wire

[hdl/dpbp_div.sv]
// pipelined restoring divider, three lanes in lockstep, one quotient bit per stage
// depends on dpbp_pkg
`default_nettype none

module dpbp_div (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire dpbp_pkg::side_t      in_side,
    input  wire dpbp_pkg::div_op_t    in_ops [dpbp_pkg::LANES],
    output logic                      out_valid,
    output dpbp_pkg::side_t           out_side,
    output logic [dpbp_pkg::NUM_W-1:0] out_quot [dpbp_pkg::LANES]
);
    import dpbp_pkg::*;

    // dividend bits shift out the top while quotient bits shift in below
    typedef struct packed {
        logic [NUM_W-1:0] nq;
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
    } lane_t;

    function automatic lane_t div_step(lane_t a);
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;
        lane_t          res;
        trial   = {a.rem, a.nq[NUM_W-1]};
        diff    = trial - {1'b0, a.den};
        ge      = trial >= {1'b0, a.den};
        res.rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        res.nq  = {a.nq[NUM_W-2:0], ge};
        res.den = a.den;
        return res;
    endfunction

    logic  valid_reg [DIV_STEPS];
    side_t side_reg  [DIV_STEPS];
    lane_t lane_reg  [DIV_STEPS][LANES];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        lane_t src [LANES];
        logic  src_valid;
        side_t src_side;

        if (k == 0)
        begin : g_first
            for (genvar l = 0; l < LANES; l++)
            begin : g_lane
                assign src[l] = '{nq: in_ops[l].num, rem: '0, den: in_ops[l].den};
            end
            assign src_valid = in_valid;
            assign src_side  = in_side;
        end
        else
        begin : g_next
            assign src       = lane_reg[k-1];
            assign src_valid = valid_reg[k-1];
            assign src_side  = side_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= src_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= src_side;
                for (int l = 0; l < LANES; l++)
                    lane_reg[k][l] <= div_step(src[l]);
            end
        end
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

    for (genvar l = 0; l < LANES; l++)
    begin : g_quot
        assign out_quot[l] = lane_reg[DIV_STEPS-1][l].nq;
    end

endmodule

`default_nettype wire

[hdl/dpbp_out.sv]
// output stage: sign and saturation of x and y, result register
// depends on dpbp_pkg
`default_nettype none

module dpbp_out (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire dpbp_pkg::side_t       in_side,
    input  wire logic [dpbp_pkg::NUM_W-1:0] in_quot [dpbp_pkg::LANES],
    output logic                       m_tvalid,
    output logic [151:0]               m_tdata
);
    import dpbp_pkg::*;

    function automatic logic [NUM_W-1:0] sat_coord(logic [NUM_W-1:0] mag,
                                                   logic neg, logic zero);
        logic [NUM_W-1:0] lim;
        lim = mag;
        if (neg && (mag > NEG_LIMIT))
            lim = NEG_LIMIT;
        else if (!neg && (mag > POS_LIMIT))
            lim = POS_LIMIT;
        // a zero offset wins even over a zero divisor
        if (zero)
            return '0;
        return neg ? (NUM_W'(0) - lim) : lim;
    endfunction

    logic             valid_reg;
    logic [151:0]     data_reg;
    logic [NUM_W-1:0] x_next;
    logic [NUM_W-1:0] y_next;

    assign x_next = sat_coord(in_quot[LANE_X], in_side.neg_x, in_side.zero_x);
    assign y_next = sat_coord(in_quot[LANE_Y], in_side.neg_y, in_side.zero_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= {in_side.red, in_side.green, in_side.blue,
                         in_quot[LANE_Z][31:0], y_next, x_next};
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

`default_nettype wire

[hdl/depth_pixel_backprojection.sv]
// Pinhole back-projection of RGB-D pixels into colored 3D points.
// Input stream s_*: one pixel per transfer. Output stream m_*: one point per
// transfer. Config port cfg_*: index 0 depth scale, 1 cx, 2 cy, 3 fx, 4 fy,
// written while cfg_we is high; other indexes are ignored.
// A pixel with zero depth or outside MAX_COLS x MAX_ROWS gives no point.
// Throughput: one pixel per clock while the receiver does not stall. The
// pipeline has two front stages, one stage per quotient bit of the 48-bit
// divider and one output register.
// Reset clears all valid bits and loads the calibration defaults
// (scale 1000, cx 5208, cy 4056, fx 8288, fy 8304).
// When the receiver stalls with a point held in the output register, the
// whole pipeline freezes and s_tready drops; s_tready is high whenever the
// output register is empty or being drained. Nothing is lost or repeated.
// Depends on dpbp_pkg, dpbp_prep, dpbp_div, dpbp_out.
`default_nettype none

module depth_pixel_backprojection #(
    parameter int MAX_COLS = 4096,
    parameter int MAX_ROWS = 4096
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pixel_column[11:0], pixel_row[23:12], depth_raw[39:24],
    // blue_in[47:40], green_in[55:48], red_in[63:56]
    input  wire logic [63:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // point_x[47:0], point_y[95:48], point_z[127:96],
    // blue_out[135:128], green_out[143:136], red_out[151:144]
    output logic [151:0]      m_tdata,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);
    import dpbp_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    en;
    logic    prep_valid;
    side_t   prep_side;
    div_op_t prep_ops [LANES];
    logic    div_valid;
    side_t   div_side;
    logic [NUM_W-1:0] div_quot [LANES];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_DEPTH_SCALE: cfg_next.depth_scale = cfg_data;
                REG_CENTER_X:    cfg_next.center_x    = cfg_data;
                REG_CENTER_Y:    cfg_next.center_y    = cfg_data;
                REG_FOCAL_X:     cfg_next.focal_x     = cfg_data;
                REG_FOCAL_Y:     cfg_next.focal_y     = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_scale <= 16'd1000;
            cfg_reg.center_x    <= 16'd5208;
            cfg_reg.center_y    <= 16'd4056;
            cfg_reg.focal_x     <= 16'd8288;
            cfg_reg.focal_y     <= 16'd8304;
        end
        else
            cfg_reg <= cfg_next;
    end

    // global advance: the output register is free or drains this cycle
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    dpbp_prep #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .cfg          (cfg_reg),
        .in_valid     (s_tvalid),
        .pixel_column (s_tdata[11:0]),
        .pixel_row    (s_tdata[23:12]),
        .depth_raw    (s_tdata[39:24]),
        .blue_in      (s_tdata[47:40]),
        .green_in     (s_tdata[55:48]),
        .red_in       (s_tdata[63:56]),
        .out_valid    (prep_valid),
        .out_side     (prep_side),
        .out_ops      (prep_ops)
    );

    dpbp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .in_side   (prep_side),
        .in_ops    (prep_ops),
        .out_valid (div_valid),
        .out_side  (div_side),
        .out_quot  (div_quot)
    );

    dpbp_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (div_valid),
        .in_side  (div_side),
        .in_quot  (div_quot),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

[hdl/dpbp_checker.sv]
// port-level checks of the back-projection block, bound to the top level
// depends on depth_pixel_backprojection_assert.svh
`default_nettype none
`include "depth_pixel_backprojection_assert.svh"

module dpbp_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [151:0] m_tdata
);

    // a held point keeps its value until the transfer
    `DPBP_ASSERT_NXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output changed while stalled")
    // a stalled output freezes the pipeline, so no pixel may enter
    `DPBP_ASSERT_IMP(a_stall_blocks, clk, rst_n, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")
    // with the output register empty the block always takes a pixel
    `DPBP_ASSERT_IMP(a_empty_ready, clk, rst_n, !m_tvalid, s_tready, "not ready with empty output")
    // nonzero depth over a 16-bit scale never rounds z down to zero
    `DPBP_ASSERT_IMP(a_z_nonzero, clk, rst_n, m_tvalid, m_tdata[127:96] != 32'd0, "point with zero depth")

endmodule

bind depth_pixel_backprojection dpbp_checker u_dpbp_checker (.*);

`default_nettype wire

[sim/point_checker.sv]
`timescale 1ns / 100ps
// point checker for the depth pixel back-projection block: watches the pixel,
// point and calibration ports, predicts each point and compares it field by field
// depends on dpbp_pkg for the register indexes, the config layout and the limits

module point_checker #(
    parameter int MAX_COLS = 4096,
    parameter int MAX_ROWS = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    // pixel_column[11:0], pixel_row[23:12], depth_raw[39:24],
    // blue_in[47:40], green_in[55:48], red_in[63:56]
    input  logic [63:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    // point_x[47:0], point_y[95:48], point_z[127:96],
    // blue_out[135:128], green_out[143:136], red_out[151:144]
    input  logic [151:0] m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    output int           mismatches,
    output int           open_points,
    output int           points_checked,
    output int           skipped_pixels
);

    import dpbp_pkg::*;

    // same layout as m_tdata, lowest field last
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [31:0] z;
        logic [47:0] y;
        logic [47:0] x;
    } point_t;

    localparam cfg_t CAL_AT_RESET = '{
        depth_scale: 16'd1000,
        center_x:    16'd5208,
        center_y:    16'd4056,
        focal_x:     16'd8288,
        focal_y:     16'd8304
    };

    cfg_t   cal = CAL_AT_RESET;
    point_t expected_points[$];
    int     error_count = 0;
    int     queued = 0;
    int     compared = 0;
    int     skipped = 0;

    assign mismatches     = error_count;
    assign open_points    = queued;
    assign points_checked = compared;
    assign skipped_pixels = skipped;

    // signed Q31.16 coordinate on one axis, exact from the raw operands
    function automatic logic [47:0] axis_coord_q16(input logic [11:0] pix,
                                                   input logic [15:0] center,
                                                   input logic [15:0] depth,
                                                   input logic [15:0] focal);
        logic [15:0] pos16;
        logic        neg;
        logic [15:0] off;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] mag;
        pos16 = {pix, 4'b0000};
        neg   = pos16 < center;
        off   = neg ? center - pos16 : pos16 - center;
        num   = ({48'd0, off} * {48'd0, depth}) << 16;
        den   = {48'd0, cal.depth_scale} * {48'd0, focal};
        if (num == '0)
            return '0;
        if (den == '0)
            mag = neg ? {16'd0, NEG_LIMIT} : {16'd0, POS_LIMIT};
        else
            mag = num / den;
        if (neg)
        begin
            if (mag > {16'd0, NEG_LIMIT})
                mag = {16'd0, NEG_LIMIT};
            mag = -mag;
            return mag[47:0];
        end
        if (mag > {16'd0, POS_LIMIT})
            mag = {16'd0, POS_LIMIT};
        return mag[47:0];
    endfunction

    function automatic point_t backproject_pixel(input logic [63:0] pixel);
        point_t      pt;
        logic [63:0] depth_q16;
        depth_q16 = {32'd0, pixel[39:24], 16'd0};
        pt.x = axis_coord_q16(pixel[11:0], cal.center_x, pixel[39:24], cal.focal_x);
        pt.y = axis_coord_q16(pixel[23:12], cal.center_y, pixel[39:24], cal.focal_y);
        if (cal.depth_scale == '0)
            pt.z = '1;
        else
            pt.z = 32'(depth_q16 / {48'd0, cal.depth_scale});
        pt.blue  = pixel[47:40];
        pt.green = pixel[55:48];
        pt.red   = pixel[63:56];
        return pt;
    endfunction

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", field, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        point_t got;
        point_t want;
        if (!rst_n)
        begin
            cal = CAL_AT_RESET;
            queued <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_points.size() == 0)
                begin
                    $error("point transfer with no pixel pending: %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    compare_field("point_x", 64'(want.x), 64'(got.x));
                    compare_field("point_y", 64'(want.y), 64'(got.y));
                    compare_field("point_z", 64'(want.z), 64'(got.z));
                    compare_field("blue_out", 64'(want.blue), 64'(got.blue));
                    compare_field("green_out", 64'(want.green), 64'(got.green));
                    compare_field("red_out", 64'(want.red), 64'(got.red));
                    compared++;
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEPTH_SCALE: cal.depth_scale = cfg_data;
                    REG_CENTER_X:    cal.center_x    = cfg_data;
                    REG_CENTER_Y:    cal.center_y    = cfg_data;
                    REG_FOCAL_X:     cal.focal_x     = cfg_data;
                    REG_FOCAL_Y:     cal.focal_y     = cfg_data;
                    default:         ; // spare indexes are ignored
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                // no depth or a pixel off the image gives no point
                if (s_tdata[39:24] == '0 || s_tdata[11:0] >= MAX_COLS
                    || s_tdata[23:12] >= MAX_ROWS)
                    skipped++;
                else
                    expected_points.insert(expected_points.size(),
                                           backproject_pixel(s_tdata));
            end
            queued <= expected_points.size();
        end
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// top of the depth pixel back-projection testbench: clock, reset, pixel and
// calibration stimulus, receiver stalls and the verdict
// depends on dpbp_pkg, depth_pixel_backprojection and point_checker

module tb_top;

    import dpbp_pkg::*;

    localparam int MAX_COLS        = 4096;
    localparam int MAX_ROWS        = 4096;
    localparam int SETTLE_CYCLES   = 64;   // pipeline is 51 deep
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 240;
    localparam int SPARE_FIRST     = REG_FOCAL_Y + 1;
    localparam int SPARE_LAST      = 2 ** $bits(cfg_index_t) - 1;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_LONG_STALL,
        RX_RARE_STALL
    } rx_mode_t;

    logic         clk;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [151:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [15:0]  cfg_data = '0;

    int mismatches;
    int open_points;
    int points_checked;
    int skipped_pixels;

    int          pixels_sent = 0;
    int          settings = 1;
    int          burst_left = 0;
    logic [15:0] cal_center_x = 16'd5208;
    logic [15:0] cal_center_y = 16'd4056;

    rx_mode_t rx_mode = RX_OPEN;
    int       mode_left = 0;
    int       run_left = 0;

    depth_pixel_backprojection #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    point_checker #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_point_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .open_points    (open_points),
        .points_checked (points_checked),
        .skipped_pixels (skipped_pixels)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("simulation failed");
        $finish;
    end

    // receiver stalls: a random pattern, drawn anew whenever its run ends
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (mode_left == 0)
            begin
                rx_mode   <= rx_mode_t'($urandom_range(RX_OPEN, RX_RARE_STALL));
                mode_left <= $urandom_range(64, 512);
            end
            else
                mode_left <= mode_left - 1;
            case (rx_mode)
                RX_OPEN:
                    m_tready <= 1'b1;
                RX_COIN:
                    m_tready <= 1'($urandom_range(0, 1));
                RX_LONG_STALL:
                begin
                    if (run_left == 0)
                    begin
                        m_tready <= !m_tready;
                        run_left <= m_tready ? $urandom_range(1, 40) : $urandom_range(1, 12);
                    end
                    else
                        run_left <= run_left - 1;
                end
                default:
                    m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ends a burst now and then with a gap of random length
    task automatic pace();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(0, 15);
        end
    endtask

    task automatic send_pixel(input logic [11:0] col, input logic [11:0] row,
                              input logic [15:0] depth, input logic [7:0] blue,
                              input logic [7:0] green, input logic [7:0] red);
        s_tdata  <= {red, green, blue, depth, row, col};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pixels_sent++;
        pace();
    endtask

    // image edges, the pixel at or next to the principal point, or a random one
    function automatic logic [11:0] pick_coord(input logic [15:0] center);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return center[15:4];
            3:       return center[15:4] + 12'd1;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic logic [15:0] pick_cal(input int lo, input int hi);
        case ($urandom_range(0, 5))
            0:       return '1;
            1:       return 16'(lo);
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    task automatic random_pixel();
        logic [15:0] depth;
        case ($urandom_range(0, 9))
            0:       depth = '0;
            1:       depth = '1;
            2:       depth = 16'($urandom_range(1, 255));
            default: depth = 16'($urandom_range(1, 65535));
        endcase
        send_pixel(pick_coord(cal_center_x), pick_coord(cal_center_y), depth,
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
    endtask

    // sender holds off until every point is out and the pipeline is empty
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (open_points != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic set_calibration(input logic [15:0] scale, input logic [15:0] cx,
                                   input logic [15:0] cy, input logic [15:0] fx,
                                   input logic [15:0] fy);
        logic [2:0]  spare;
        logic [15:0] junk;
        spare = 3'($urandom_range(SPARE_FIRST, SPARE_LAST));
        junk  = 16'($urandom_range(0, 65535));
        wait_drained();
        write_reg(spare, junk);
        write_reg(REG_DEPTH_SCALE, scale);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_FOCAL_X, fx);
        write_reg(REG_FOCAL_Y, fy);
        cfg_we <= 1'b0;
        cal_center_x = cx;
        cal_center_y = cy;
        settings++;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // calibration from reset
        send_pixel(12'd0, 12'd0, 16'd1, 8'h00, 8'h00, 8'h00);
        send_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(12'hFFF, 12'd0, 16'd0, 8'h55, 8'hAA, 8'h55);
        send_pixel(12'd0, 12'hFFF, 16'd0, 8'hAA, 8'h55, 8'hAA);
        send_pixel(12'd325, 12'd253, 16'd1000, 8'h12, 8'h34, 8'h56);
        send_pixel(12'd326, 12'd254, 16'h8000, 8'h9A, 8'hBC, 8'hDE);

        // principal point on a whole pixel: zero offset on one or both axes
        set_calibration(16'd1000, 16'd5120, 16'd3840, 16'd8288, 16'd8304);
        send_pixel(12'd320, 12'd240, 16'd1500, 8'h01, 8'h02, 8'h03);
        send_pixel(12'd320, 12'd0, 16'hFFFF, 8'h04, 8'h05, 8'h06);
        send_pixel(12'd0, 12'd240, 16'hFFFF, 8'h07, 8'h08, 8'h09);

        // tiny divisors: positive saturation
        set_calibration(16'd1, 16'd0, 16'd0, 16'd1, 16'd1);
        send_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 8'h80, 8'h40, 8'h20);
        send_pixel(12'd0, 12'd0, 16'hFFFF, 8'h10, 8'h08, 8'h04);
        send_pixel(12'hFFF, 12'd1, 16'd1, 8'h02, 8'h01, 8'h7F);

        // principal point past the image: negative saturation
        set_calibration(16'd1, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1);
        send_pixel(12'd0, 12'd0, 16'hFFFF, 8'hC3, 8'h3C, 8'hE7);
        send_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 8'h18, 8'h81, 8'h66);

        // zero depth scale
        set_calibration(16'd0, 16'd5200, 16'd4048, 16'd8288, 16'd8304);
        send_pixel(12'd325, 12'd253, 16'd700, 8'h11, 8'h22, 8'h33);
        send_pixel(12'd0, 12'hFFF, 16'd1, 8'h44, 8'h55, 8'h66);

        // zero focal lengths
        set_calibration(16'd1000, 16'd5200, 16'd4048, 16'd0, 16'd0);
        send_pixel(12'd325, 12'd253, 16'd10, 8'h77, 8'h88, 8'h99);
        send_pixel(12'd0, 12'd0, 16'd10, 8'hAA, 8'hBB, 8'hCC);
        send_pixel(12'hFFF, 12'hFFF, 16'd10, 8'hDD, 8'hEE, 8'hFF);

        // every register at its top
        set_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(12'd0, 12'd0, 16'hFFFF, 8'h5A, 8'hA5, 8'h0F);
        send_pixel(12'hFFF, 12'hFFF, 16'd1, 8'hF0, 8'h96, 8'h69);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_calibration(pick_cal(1, 10000), pick_cal(0, 65535), pick_cal(0, 65535),
                            pick_cal(1, 32000), pick_cal(1, 32000));
            repeat (ITEMS_PER_PHASE) random_pixel();
        end

        wait_drained();
        $display("%0d pixels under %0d calibration settings,", pixels_sent, settings);
        $display("%0d points compared, %0d without a point", points_checked,
                 skipped_pixels);
        if (mismatches == 0 && open_points == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
